[src/name_directory_table_top_defines.svh]
// ----------------------------------------------------------------------------
// Name directory table: assertion macros
// Shared macros for the concurrent checks of the name directory table. They
// sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NAME_DIRECTORY_TABLE_TOP_DEFINES_SVH
`define NAME_DIRECTORY_TABLE_TOP_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define NDT_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");

// A consequence that must hold in the same cycle as its antecedent.
`define NDT_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// A consequence that must hold in the cycle after its antecedent.
`define NDT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

[src/ndt_pkg.sv]
// ----------------------------------------------------------------------------
// Name directory table package
// Sizes, codes, command and status structures and the name canonicalizing
// function shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package ndt_pkg;

    // Table geometry.
    localparam int ENTRIES    = 16;
    localparam int ADDR_W     = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int NAME_BYTES = 19;
    localparam int NAME_W     = NAME_BYTES * 8;
    localparam int INDEX_W    = 4;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

    // Operation codes carried by an input transaction.
    typedef enum logic [1:0] {
        FUNC_CREATE = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_SEARCH = 2'd2,
        FUNC_LIST   = 2'd3
    } func_t;

    // Result status codes.
    typedef enum logic [2:0] {
        RES_CREATED  = 3'd0,
        RES_EXISTS   = 3'd1,
        RES_FULL     = 3'd2,
        RES_DELETED  = 3'd3,
        RES_NOTFOUND = 3'd4,
        RES_FOUND    = 3'd5,
        RES_EMPTY    = 3'd6,
        RES_LISTED   = 3'd7
    } res_status_t;

    // Source of the index reported with a single result.
    typedef enum logic [1:0] {
        SEL_ZERO  = 2'd0,
        SEL_IDX   = 2'd1,
        SEL_COUNT = 2'd2,
        SEL_SLOT  = 2'd3
    } idx_sel_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE      = 4'd0,
        S_DISPATCH  = 4'd1,
        S_SCAN_RD   = 4'd2,
        S_SCAN_CMP  = 4'd3,
        S_SHIFT_RD  = 4'd4,
        S_SHIFT_WR  = 4'd5,
        S_EMIT      = 4'd6,
        S_LIST_RD   = 4'd7,
        S_LIST_EMIT = 4'd8
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        load_in;
        logic        idx_inc;
        logic        slot_save;
        logic        ram_rd;
        logic        wr_new;
        logic        wr_shift;
        logic        cnt_inc;
        logic        cnt_dec;
        logic        res_load;
        res_status_t res_code;
        idx_sel_t    res_sel;
        logic        out_single;
        logic        out_list;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        func_t            func;
        logic             full;
        logic             empty;
        logic             scan_end;
        logic             match;
        logic             list_last;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } sts_t;

    // Clear every byte that follows the first zero byte of a name.
    function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] res;
        logic              alive;
        res   = '0;
        alive = 1'b1;
        for (int i = 0; i < NAME_BYTES; i++) begin
            if (alive) begin
                res[8*i +: 8] = raw[8*i +: 8];
            end
            if (raw[8*i +: 8] == 8'h00) begin
                alive = 1'b0;
            end
        end
        return res;
    endfunction

endpackage

[src/ndt_in_if.sv]
// ----------------------------------------------------------------------------
// Name directory table request channel
// Valid/ready channel that carries one operation and one name per transaction.
// ----------------------------------------------------------------------------
interface ndt_in_if;

    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [63:0] name_lo;
    logic [63:0] name_mid;
    logic [23:0] name_hi;

    modport source (output valid, output func, output name_lo, output name_mid,
                    output name_hi, input ready);
    modport sink   (input valid, input func, input name_lo, input name_mid,
                    input name_hi, output ready);

endinterface

[src/ndt_out_if.sv]
// ----------------------------------------------------------------------------
// Name directory table result channel
// Valid/ready channel that carries one result per transaction.
// ----------------------------------------------------------------------------
interface ndt_out_if;

    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  entry_index;
    logic [63:0] out_name_lo;
    logic [63:0] out_name_mid;
    logic [23:0] out_name_hi;
    logic        last;

    modport source (output valid, output status, output entry_index,
                    output out_name_lo, output out_name_mid, output out_name_hi,
                    output last, input ready);
    modport sink   (input valid, input status, input entry_index,
                    input out_name_lo, input out_name_mid, input out_name_hi,
                    input last, output ready);

endinterface

[src/ndt_ram.sv]
// ----------------------------------------------------------------------------
// Name directory table RAM
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ndt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/ndt_ctrl.sv]
// ----------------------------------------------------------------------------
// Name directory table controller
// State machine that sequences scans, shifts, writes and result transactions.
// ----------------------------------------------------------------------------
module ndt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ndt_pkg::sts_t sts,
    output ndt_pkg::cmd_t cmd
);

    ndt_pkg::state_t state_reg;
    ndt_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ndt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ndt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ndt_pkg::S_DISPATCH;
                end
            end
            ndt_pkg::S_DISPATCH:
            begin
                if (sts.func == ndt_pkg::FUNC_CREATE && sts.full)
                begin
                    state_next = ndt_pkg::S_EMIT;
                end
                else if (sts.func != ndt_pkg::FUNC_CREATE && sts.empty)
                begin
                    state_next = ndt_pkg::S_EMIT;
                end
                else if (sts.func == ndt_pkg::FUNC_LIST)
                begin
                    state_next = ndt_pkg::S_LIST_RD;
                end
                else
                begin
                    state_next = ndt_pkg::S_SCAN_RD;
                end
            end
            ndt_pkg::S_SCAN_RD:
            begin
                if (sts.scan_end)
                begin
                    state_next = ndt_pkg::S_EMIT;
                end
                else
                begin
                    state_next = ndt_pkg::S_SCAN_CMP;
                end
            end
            ndt_pkg::S_SCAN_CMP:
            begin
                if (!sts.match)
                begin
                    state_next = ndt_pkg::S_SCAN_RD;
                end
                else if (sts.func == ndt_pkg::FUNC_DELETE)
                begin
                    state_next = ndt_pkg::S_SHIFT_RD;
                end
                else
                begin
                    state_next = ndt_pkg::S_EMIT;
                end
            end
            ndt_pkg::S_SHIFT_RD:
            begin
                if (sts.scan_end)
                begin
                    state_next = ndt_pkg::S_EMIT;
                end
                else
                begin
                    state_next = ndt_pkg::S_SHIFT_WR;
                end
            end
            ndt_pkg::S_SHIFT_WR:
            begin
                state_next = ndt_pkg::S_SHIFT_RD;
            end
            ndt_pkg::S_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ndt_pkg::S_IDLE;
                end
            end
            ndt_pkg::S_LIST_RD:
            begin
                state_next = ndt_pkg::S_LIST_EMIT;
            end
            ndt_pkg::S_LIST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.list_last ? ndt_pkg::S_IDLE : ndt_pkg::S_LIST_RD;
                end
            end
            default:
            begin
                state_next = ndt_pkg::S_IDLE;
            end
        endcase
    end

    // Output logic: commands to the datapath.
    always_comb
    begin
        cmd          = '0;
        cmd.res_code = ndt_pkg::RES_CREATED;
        cmd.res_sel  = ndt_pkg::SEL_ZERO;
        in_ready     = 1'b0;
        unique case (state_reg)
            ndt_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ndt_pkg::S_DISPATCH:
            begin
                if (sts.func == ndt_pkg::FUNC_CREATE && sts.full)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ndt_pkg::RES_FULL;
                end
                else if (sts.func != ndt_pkg::FUNC_CREATE && sts.empty)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ndt_pkg::RES_EMPTY;
                end
            end
            ndt_pkg::S_SCAN_RD:
            begin
                if (sts.scan_end)
                begin
                    // No slot matched: a create appends, the others miss.
                    cmd.res_load = 1'b1;
                    if (sts.func == ndt_pkg::FUNC_CREATE)
                    begin
                        cmd.wr_new   = 1'b1;
                        cmd.cnt_inc  = 1'b1;
                        cmd.res_code = ndt_pkg::RES_CREATED;
                        cmd.res_sel  = ndt_pkg::SEL_COUNT;
                    end
                    else
                    begin
                        cmd.res_code = ndt_pkg::RES_NOTFOUND;
                    end
                end
                else
                begin
                    cmd.ram_rd = 1'b1;
                end
            end
            ndt_pkg::S_SCAN_CMP:
            begin
                if (!sts.match)
                begin
                    cmd.idx_inc = 1'b1;
                end
                else if (sts.func == ndt_pkg::FUNC_DELETE)
                begin
                    cmd.slot_save = 1'b1;
                    cmd.idx_inc   = 1'b1;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = ndt_pkg::SEL_IDX;
                    cmd.res_code = (sts.func == ndt_pkg::FUNC_CREATE) ?
                                   ndt_pkg::RES_EXISTS : ndt_pkg::RES_FOUND;
                end
            end
            ndt_pkg::S_SHIFT_RD:
            begin
                if (sts.scan_end)
                begin
                    cmd.cnt_dec  = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_code = ndt_pkg::RES_DELETED;
                    cmd.res_sel  = ndt_pkg::SEL_SLOT;
                end
                else
                begin
                    cmd.ram_rd = 1'b1;
                end
            end
            ndt_pkg::S_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
            end
            ndt_pkg::S_EMIT:
            begin
                cmd.out_single = sts.out_free;
            end
            ndt_pkg::S_LIST_RD:
            begin
                cmd.ram_rd = 1'b1;
            end
            ndt_pkg::S_LIST_EMIT:
            begin
                cmd.out_list = sts.out_free;
                cmd.idx_inc  = sts.out_free && !sts.list_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[src/ndt_dp.sv]
// ----------------------------------------------------------------------------
// Name directory table datapath
// Request registers, scan index, entry count, name RAM, comparator and the
// output register of the result channel.
// ----------------------------------------------------------------------------
module ndt_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  ndt_pkg::cmd_t cmd,
    output ndt_pkg::sts_t sts,
    input  logic [1:0]    in_func,
    input  logic [63:0]   in_name_lo,
    input  logic [63:0]   in_name_mid,
    input  logic [23:0]   in_name_hi,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [2:0]    out_status,
    output logic [3:0]    out_entry_index,
    output logic [63:0]   out_name_lo,
    output logic [63:0]   out_name_mid,
    output logic [23:0]   out_name_hi,
    output logic          out_last
);

    localparam int CW = ndt_pkg::CNT_W;
    localparam int AW = ndt_pkg::ADDR_W;
    localparam int NW = ndt_pkg::NAME_W;
    localparam int IW = ndt_pkg::INDEX_W;

    ndt_pkg::func_t           func_reg,  func_next;
    logic [NW-1:0]            name_reg,  name_next;
    logic [CW-1:0]            idx_reg,   idx_next;
    logic [CW-1:0]            slot_reg,  slot_next;
    logic [CW-1:0]            cnt_reg,   cnt_next;
    ndt_pkg::res_status_t     res_status_reg, res_status_next;
    logic [IW-1:0]            res_index_reg,  res_index_next;
    logic                     out_valid_reg,  out_valid_next;
    logic [2:0]               out_status_reg, out_status_next;
    logic [IW-1:0]            out_index_reg,  out_index_next;
    logic [NW-1:0]            out_name_reg,   out_name_next;
    logic                     out_last_reg,   out_last_next;

    logic [CW-1:0]            idx_prev;
    logic                     list_last;
    logic                     ram_wr_en;
    logic [AW-1:0]            ram_wr_addr;
    logic [NW-1:0]            ram_wr_data;
    logic [NW-1:0]            ram_rd_data;

    assign idx_prev  = idx_reg - CW'(1);
    assign list_last = (idx_reg + CW'(1)) == cnt_reg;

    // Request capture; the name is canonicalized on the way in.
    always_comb
    begin
        func_next = func_reg;
        name_next = name_reg;
        if (cmd.load_in)
        begin
            func_next = ndt_pkg::func_t'(in_func);
            name_next = ndt_pkg::canon_name({in_name_hi, in_name_mid, in_name_lo});
        end
    end

    // Scan index, matched slot and entry count.
    always_comb
    begin
        idx_next  = idx_reg;
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (cmd.load_in)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CW'(1);
        end
        if (cmd.slot_save)
        begin
            slot_next = idx_reg;
        end
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    // Pending single result.
    always_comb
    begin
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        if (cmd.res_load)
        begin
            res_status_next = cmd.res_code;
            case (cmd.res_sel)
                ndt_pkg::SEL_IDX:   res_index_next = IW'(idx_reg);
                ndt_pkg::SEL_COUNT: res_index_next = IW'(cnt_reg);
                ndt_pkg::SEL_SLOT:  res_index_next = IW'(slot_reg);
                default:            res_index_next = '0;
            endcase
        end
    end

    // Output register of the result channel.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_name_next   = out_name_reg;
        out_last_next   = out_last_reg;
        if (cmd.out_single)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_index_next  = res_index_reg;
            out_name_next   = '0;
            out_last_next   = 1'b1;
        end
        else if (cmd.out_list)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ndt_pkg::RES_LISTED;
            out_index_next  = IW'(idx_reg);
            out_name_next   = ram_rd_data;
            out_last_next   = list_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        name_reg       <= name_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_name_reg   <= out_name_next;
        out_last_reg   <= out_last_next;
    end

    // A new name goes to the first free slot; a shift moves an entry down one.
    assign ram_wr_en   = cmd.wr_new || cmd.wr_shift;
    assign ram_wr_addr = cmd.wr_new ? cnt_reg[AW-1:0] : idx_prev[AW-1:0];
    assign ram_wr_data = cmd.wr_new ? name_reg : ram_rd_data;

    ndt_ram #(
        .WIDTH (NW),
        .DEPTH (ndt_pkg::ENTRIES)
    ) u_name_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.ram_rd),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // Status back to the controller.
    always_comb
    begin
        sts.func      = func_reg;
        sts.full      = cnt_reg == ndt_pkg::FULL_COUNT;
        sts.empty     = cnt_reg == '0;
        sts.scan_end  = idx_reg == cnt_reg;
        sts.match     = ram_rd_data == name_reg;
        sts.list_last = list_last;
        sts.out_free  = !out_valid_reg || out_ready;
        sts.count     = cnt_reg;
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_entry_index = out_index_reg;
    assign out_name_lo     = out_name_reg[63:0];
    assign out_name_mid    = out_name_reg[127:64];
    assign out_name_hi     = out_name_reg[151:128];
    assign out_last        = out_last_reg;

endmodule

[src/name_directory_table_top.sv]
// ----------------------------------------------------------------------------
// Name directory table
// Single-level directory of up to ENTRIES zero-padded names of 19 bytes.
// ----------------------------------------------------------------------------
// Usage:
// A request transaction on in_ch carries an operation (create, delete, search,
// list) and a name. Each request yields one result transaction on out_ch, or
// for a list of a non-empty table one per stored entry, with last set on the
// final one. The table is held in a single-port-read RAM and searched one
// slot at a time, so a request is handled by a sequencer and the next request
// is taken only after the current one has handed off its final result.
// An append or a miss scans every stored entry, a hit stops the scan at the
// matching slot, and a delete then moves each later entry down one slot.
// Full and empty answers need no scan. A list reads the entries in order and
// gives one result per entry.
// The result sits in an output register; a stalled receiver holds the block
// as soon as a further result is due while that register is still full.
// Reset (rst_n low) empties the table and drops any pending result.
// ----------------------------------------------------------------------------
`include "name_directory_table_top_defines.svh"

module name_directory_table_top (
    input  logic      clk,
    input  logic      rst_n,
    ndt_in_if.sink    in_ch,
    ndt_out_if.source out_ch
);

    ndt_pkg::cmd_t cmd;
    ndt_pkg::sts_t sts;
    logic          in_ready;

    assign in_ch.ready = in_ready;

    // Sequencer.
    ndt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Storage, compare and result register.
    ndt_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_func         (in_ch.func),
        .in_name_lo      (in_ch.name_lo),
        .in_name_mid     (in_ch.name_mid),
        .in_name_hi      (in_ch.name_hi),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .out_status      (out_ch.status),
        .out_entry_index (out_ch.entry_index),
        .out_name_lo     (out_ch.out_name_lo),
        .out_name_mid    (out_ch.out_name_mid),
        .out_name_hi     (out_ch.out_name_hi),
        .out_last        (out_ch.last)
    );

    // The entry count never passes the table size.
    `NDT_ASSERT_HOLDS(a_count_bound, sts.count <= ndt_pkg::FULL_COUNT)
    // The RAM write port never serves an append and a shift together.
    `NDT_ASSERT_HOLDS(a_single_write, !(cmd.wr_new && cmd.wr_shift))
    // A result is loaded only when the output register is free.
    `NDT_ASSERT_IMPLIES(a_out_free, cmd.out_single || cmd.out_list, sts.out_free)
    // Accepting a request leaves the entry count untouched in the next cycle.
    `NDT_ASSERT_NEXT(a_accept_count, in_ch.valid && in_ready, $stable(sts.count))

endmodule

[tb/tb_name_directory_table_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Name directory table testbench
// Drives create, delete, search and list requests into the directory table
// and predicts every result from a behavioral copy of the table. It starts
// with a short directed sequence over the empty, full and name-end cases,
// then runs random bursts that fill, drain and probe the table. Both channel
// sides idle at random, and the receiver holds off for long stretches so
// that the block stalls its request channel.
// ----------------------------------------------------------------------------
module tb_name_directory_table_top;

    typedef struct packed {
        ndt_pkg::func_t func;
        logic [151:0]   name;
    } dir_req_t;

    typedef struct packed {
        ndt_pkg::res_status_t status;
        logic [3:0]           index;
        logic [151:0]         name;
        logic                 last;
    } dir_result_t;

    localparam int POOL_SIZE  = 24;
    localparam int RAND_ITEMS = 220;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_LEN  = 120;

    logic clk;
    logic rst_n;

    ndt_in_if  in_if ();
    ndt_out_if out_if ();

    name_directory_table_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if)
    );

    // Stimulus waiting to be offered, and results still owed by the block.
    dir_req_t     req_queue[$];
    dir_result_t  results_due[$];

    // Behavioral copy of the directory.
    logic [151:0] tbl_names[ndt_pkg::ENTRIES];
    int           tbl_count;

    // Names reused across requests so that lookups hit.
    logic [151:0] known_names[POOL_SIZE];

    dir_req_t     offered;
    int           req_accepted;
    int           hold_left;
    int           hold_mark;
    bit           mismatch_seen;

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle percentages step through three phases as requests are consumed.
    function automatic int send_gap_pct(int n);
        if (n < 90)
        begin
            return 34;
        end
        else if (n < 180)
        begin
            return 79;
        end
        return 0;
    endfunction

    function automatic int recv_gap_pct(int n);
        if (n < 90)
        begin
            return 79;
        end
        else if (n < 180)
        begin
            return 34;
        end
        return 0;
    endfunction

    // A name ends at its first zero byte; everything after it reads as zero.
    function automatic logic [151:0] name_trim(logic [151:0] raw);
        logic [151:0] res;
        bit           ended;
        res   = '0;
        ended = 1'b0;
        for (int b = 0; b < 19; b++)
        begin
            if (raw[8*b +: 8] == 8'h00)
            begin
                ended = 1'b1;
            end
            if (!ended)
            begin
                res[8*b +: 8] = raw[8*b +: 8];
            end
        end
        return res;
    endfunction

    // Random name of the given length, all bytes nonzero.
    function automatic logic [151:0] rand_name(int len);
        logic [151:0] res;
        res = '0;
        for (int b = 0; b < len; b++)
        begin
            res[8*b +: 8] = 8'($urandom_range(1, 255));
        end
        return res;
    endfunction

    // Fill the bytes after the terminator with random garbage.
    function automatic logic [151:0] soil(logic [151:0] nm);
        logic [151:0] res;
        bit           ended;
        res   = nm;
        ended = 1'b0;
        for (int b = 0; b < 19; b++)
        begin
            if (ended)
            begin
                res[8*b +: 8] = 8'($urandom_range(0, 255));
            end
            else if (nm[8*b +: 8] == 8'h00)
            begin
                ended = 1'b1;
            end
        end
        return res;
    endfunction

    // A known name, with a garbage tail half of the time.
    function automatic logic [151:0] pick_known();
        logic [151:0] nm;
        nm = known_names[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(0, 1) == 1)
        begin
            nm = soil(nm);
        end
        return nm;
    endfunction

    function automatic void enqueue(ndt_pkg::func_t fn, logic [151:0] nm);
        dir_req_t r;
        r.func = fn;
        r.name = nm;
        req_queue.push_back(r);
    endfunction

    function automatic void due_push(ndt_pkg::res_status_t st, int idx,
                                     logic [151:0] nm, bit lst);
        dir_result_t e;
        e.status = st;
        e.index  = 4'(idx);
        e.name   = nm;
        e.last   = lst;
        results_due.push_back(e);
    endfunction

    // Apply one request to the directory copy and queue the results it owes.
    function automatic void directory_apply(dir_req_t r);
        logic [151:0] nm;
        int           hit;
        nm  = name_trim(r.name);
        hit = -1;
        for (int i = 0; i < tbl_count; i++)
        begin
            if (hit < 0 && tbl_names[i] == nm)
            begin
                hit = i;
            end
        end
        if (r.func == ndt_pkg::FUNC_CREATE)
        begin
            if (tbl_count >= ndt_pkg::ENTRIES)
            begin
                due_push(ndt_pkg::RES_FULL, 0, '0, 1'b1);
            end
            else if (hit >= 0)
            begin
                due_push(ndt_pkg::RES_EXISTS, hit, '0, 1'b1);
            end
            else
            begin
                tbl_names[tbl_count] = nm;
                due_push(ndt_pkg::RES_CREATED, tbl_count, '0, 1'b1);
                tbl_count++;
            end
        end
        else if (tbl_count == 0)
        begin
            due_push(ndt_pkg::RES_EMPTY, 0, '0, 1'b1);
        end
        else
        begin
            case (r.func)
                ndt_pkg::FUNC_DELETE:
                begin
                    if (hit < 0)
                    begin
                        due_push(ndt_pkg::RES_NOTFOUND, 0, '0, 1'b1);
                    end
                    else
                    begin
                        for (int i = hit; i + 1 < tbl_count; i++)
                        begin
                            tbl_names[i] = tbl_names[i + 1];
                        end
                        tbl_count--;
                        due_push(ndt_pkg::RES_DELETED, hit, '0, 1'b1);
                    end
                end
                ndt_pkg::FUNC_SEARCH:
                begin
                    if (hit < 0)
                    begin
                        due_push(ndt_pkg::RES_NOTFOUND, 0, '0, 1'b1);
                    end
                    else
                    begin
                        due_push(ndt_pkg::RES_FOUND, hit, '0, 1'b1);
                    end
                end
                default:
                begin
                    for (int i = 0; i < tbl_count; i++)
                    begin
                        due_push(ndt_pkg::RES_LISTED, i, tbl_names[i],
                                 i + 1 == tbl_count);
                    end
                end
            endcase
        end
    endfunction

    function automatic void check_field(string fld, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h, actual %h", fld, want, got);
            mismatch_seen = 1'b1;
        end
    endfunction

    // Request driver: predict each accepted transaction, then offer the next.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_if.valid && in_if.ready)
            begin
                directory_apply(offered);
                req_accepted <= req_accepted + 1;
            end
            if (!(in_if.valid && !in_if.ready))
            begin
                if (req_queue.size() > 0 &&
                    $urandom_range(0, 99) >= send_gap_pct(req_accepted))
                begin
                    offered        = req_queue.pop_front();
                    in_if.valid    <= 1'b1;
                    in_if.func     <= offered.func;
                    in_if.name_lo  <= offered.name[63:0];
                    in_if.name_mid <= offered.name[127:64];
                    in_if.name_hi  <= offered.name[151:128];
                end
                else
                begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-offs at two points of the run.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if ((req_accepted == 40 || req_accepted == 200) && hold_mark != req_accepted)
        begin
            hold_left <= HOLD_LEN;
            hold_mark <= req_accepted;
        end
    end

    // Result monitor: compare each accepted transaction, then set ready.
    always @(posedge clk)
    begin
        dir_result_t e;
        if (rst_n)
        begin
            if (out_if.valid && out_if.ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result with no request owing it: status %0d index %0d",
                           out_if.status, out_if.entry_index);
                    mismatch_seen = 1'b1;
                end
                else
                begin
                    e = results_due.pop_front();
                    check_field("status", 64'(e.status), 64'(out_if.status));
                    check_field("entry_index", 64'(e.index), 64'(out_if.entry_index));
                    check_field("out_name_lo", e.name[63:0], out_if.out_name_lo);
                    check_field("out_name_mid", e.name[127:64], out_if.out_name_mid);
                    check_field("out_name_hi", 64'(e.name[151:128]), 64'(out_if.out_name_hi));
                    check_field("last", 64'(e.last), 64'(out_if.last));
                end
            end
            out_if.ready <= (hold_left == 0) &&
                            ($urandom_range(0, 99) >= recv_gap_pct(req_accepted));
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int mode;
        int burst;
        int rand_cnt;
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_if.valid    = 1'b0;
        in_if.func     = ndt_pkg::FUNC_CREATE;
        in_if.name_lo  = '0;
        in_if.name_mid = '0;
        in_if.name_hi  = '0;
        out_if.ready   = 1'b0;
        tbl_count      = 0;
        req_accepted   = 0;
        hold_left      = 0;
        hold_mark      = -1;
        mismatch_seen  = 1'b0;
        rand_cnt       = 0;

        for (int i = 0; i < POOL_SIZE - 1; i++)
        begin
            known_names[i] = rand_name(1 + i % 19);
        end
        known_names[POOL_SIZE - 1] = '0;

        // Directed: empty table, empty name, name end, full table, full list.
        enqueue(ndt_pkg::FUNC_LIST, rand_name(5));
        enqueue(ndt_pkg::FUNC_SEARCH, rand_name(19));
        enqueue(ndt_pkg::FUNC_DELETE, '0);
        enqueue(ndt_pkg::FUNC_CREATE, '0);
        enqueue(ndt_pkg::FUNC_CREATE, soil('0));
        enqueue(ndt_pkg::FUNC_CREATE, {152{1'b1}});
        enqueue(ndt_pkg::FUNC_SEARCH, {152{1'b1}});
        enqueue(ndt_pkg::FUNC_DELETE, soil('0));
        enqueue(ndt_pkg::FUNC_DELETE, known_names[3]);
        for (int i = 0; i < 15; i++)
        begin
            enqueue(ndt_pkg::FUNC_CREATE, soil(known_names[i]));
        end
        enqueue(ndt_pkg::FUNC_CREATE, {152{1'b1}});
        enqueue(ndt_pkg::FUNC_LIST, '0);

        // Random bursts that fill, drain and probe the table.
        while (rand_cnt < RAND_ITEMS)
        begin
            mode = $urandom_range(0, 9);
            if (mode <= 2)
            begin
                burst = $urandom_range(6, 20);
                repeat (burst) enqueue(ndt_pkg::FUNC_CREATE, pick_known());
            end
            else if (mode <= 4)
            begin
                burst = $urandom_range(3, 12);
                repeat (burst) enqueue(ndt_pkg::FUNC_DELETE, pick_known());
            end
            else if (mode <= 7)
            begin
                burst = $urandom_range(4, 10);
                repeat (burst)
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        enqueue(ndt_pkg::func_t'($urandom_range(0, 3)),
                                soil(rand_name($urandom_range(0, 19))));
                    end
                    else
                    begin
                        enqueue(ndt_pkg::func_t'($urandom_range(0, 3)), pick_known());
                    end
                end
            end
            else if (mode == 8)
            begin
                burst = 1;
                enqueue(ndt_pkg::FUNC_LIST, pick_known());
            end
            else
            begin
                burst = $urandom_range(1, 3);
                repeat (burst)
                begin
                    enqueue(ndt_pkg::func_t'($urandom_range(0, 3)),
                            152'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()}));
                end
            end
            rand_cnt += burst;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every request to go in and every result to come out.
        do
        begin
            @(negedge clk);
        end
        while (req_queue.size() != 0 || in_if.valid || results_due.size() != 0);
        repeat (DRAIN_LEN) @(negedge clk);

        if (!mismatch_seen && results_due.size() == 0)
        begin
            $display("PASS name_directory_table_top");
        end
        else
        begin
            $display("FAIL name_directory_table_top");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5_000_000;
        $display("FAIL name_directory_table_top");
        $finish;
    end

endmodule
